// ===== src/ntcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature package
// Shared widths, constants, status codes and register indexes.
// ----------------------------------------------------------------------------
package ntcdt_pkg;

    localparam int MV_W   = 13;
    localparam int RES_W  = 20;
    localparam int BETA_W = 14;
    localparam int CFG_W  = 20;
    localparam int IDX_W  = 2;

    // Log unit: argument width, mantissa fraction bits and exponent width.
    localparam int XW        = 33;
    localparam int MANT_BITS = 30;
    localparam int MW        = MANT_BITS + 1;
    localparam int EW        = 6;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [14:0] T25_CENTI = 15'd29815;
    localparam logic [21:0] TN_SCALE  = 22'd2981500;
    localparam logic [9:0]  MILLI     = 10'd1000;
    localparam logic [6:0]  HUNDRED   = 7'd100;

    // Kelvin quotient in hundredths and its limits.
    localparam int          KQW      = 17;
    localparam logic [16:0] K_OFFSET = 17'd27315;
    localparam logic [16:0] K_TOP    = 17'd60082;
    localparam logic [15:0] TEMP_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_REF  = 3'd1,
        ST_BAD_RES  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BAD_BETA = 3'd4,
        ST_BAD_NOM  = 3'd5,
        ST_LOW_RES  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_REFERENCE = 2'd0,
        CFG_FIXED_RES = 2'd1,
        CFG_NOMINAL   = 2'd2,
        CFG_BETA      = 2'd3
    } cfg_index_t;

endpackage

// ===== src/ntcdt_if.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature stream interfaces
// Valid/ready channels for the input sample word and the result word.
// ----------------------------------------------------------------------------
interface ntcdt_in_if import ntcdt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] divider_mv;

    modport source (output valid, output divider_mv, input ready);
    modport sink   (input valid, input divider_mv, output ready);
endinterface

interface ntcdt_out_if import ntcdt_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] temperature_centi_c;
    logic [31:0] resistance_ohm;
    logic [23:0] current_ua;
    logic [23:0] power_uw;
    logic [2:0]  status;

    modport source (output valid, output temperature_centi_c, output resistance_ohm,
                    output current_ua, output power_uw, output status, input ready);
    modport sink   (input valid, input temperature_centi_c, input resistance_ohm,
                    input current_ua, input power_uw, input status, output ready);
endinterface

// ===== src/ntcdt_delay.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature delay line
// Shift line that keeps side values aligned with the pipeline stages.
// ----------------------------------------------------------------------------
module ntcdt_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign q = d;
        end
        else begin : g_line
            logic [W-1:0] tap_reg [0:DEPTH-1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= d;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign q = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== src/ntcdt_div.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ntcdt_div #(
    parameter int NW = 24,
    parameter int DW = 20,
    parameter int QW = 24
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  r_reg [0:QW-1];
    logic [DW-1:0] d_reg [0:QW-1];
    logic [QW-1:0] q_reg [0:QW-1];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            localparam int J = QW - 1 - s;
            logic [W-1:0]  r_in;
            logic [DW-1:0] d_in;
            logic [QW-1:0] q_in;
            logic [W-1:0]  dsh;
            logic          ge;
            logic [W-1:0]  r_next;
            logic [QW-1:0] q_next;

            if (s == 0) begin : g_first
                assign r_in = W'(n);
                assign d_in = d;
                assign q_in = '0;
            end
            else begin : g_rest
                assign r_in = r_reg[s-1];
                assign d_in = d_reg[s-1];
                assign q_in = q_reg[s-1];
            end

            always_comb
            begin
                dsh       = W'(d_in) << J;
                ge        = (r_in >= dsh);
                r_next    = ge ? (r_in - dsh) : r_in;
                q_next    = q_in;
                q_next[J] = ge;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[s] <= r_next;
                    d_reg[s] <= d_in;
                    q_reg[s] <= q_next;
                end
            end
        end
    endgenerate

    assign q = q_reg[QW-1];

endmodule

// ===== src/ntcdt_log.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature natural log
// Pipelined ln: normalize, one squaring per fraction bit, scale by ln 2.
// ----------------------------------------------------------------------------
module ntcdt_log import ntcdt_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int LNW       = FRAC_BITS + 5
) (
    input  logic           clk,
    input  logic           en,
    input  logic [XW-1:0]  x,
    output logic [LNW-1:0] ln
);

    localparam int SW = XW + MANT_BITS;
    localparam int LW = EW + FRAC_BITS;
    localparam int PW = LW + 32;

    logic [XW-1:0]        x_fix;
    logic [EW-1:0]        e_next;
    logic [XW-1:0]        x0_reg;
    logic [EW-1:0]        e0_reg;
    logic [SW-1:0]        sh;
    logic [MW-1:0]        m_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] f_reg [0:FRAC_BITS];
    logic [EW-1:0]        e_reg [0:FRAC_BITS];
    logic [LW-1:0]        l2;
    logic [PW-1:0]        prod;
    logic [LNW-1:0]       ln_reg;

    // Zero is taken as one; e is the position of the top set bit.
    always_comb
    begin
        x_fix  = (x == '0) ? XW'(1) : x;
        e_next = '0;
        for (int i = 1; i < XW; i++)
        begin
            if (x_fix[i])
            begin
                e_next = EW'(i);
            end
        end
    end

    assign sh = {x0_reg, MANT_BITS'(0)} >> e0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= x_fix;
            e0_reg   <= e_next;
            m_reg[0] <= sh[MW-1:0];
            f_reg[0] <= '0;
            e_reg[0] <= e0_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < FRAC_BITS; g++) begin : g_sq
            logic [2*MW-1:0] sq;
            logic [MW:0]     t;

            assign sq = (2*MW)'(m_reg[g]) * (2*MW)'(m_reg[g]);
            assign t  = sq[MANT_BITS +: MW+1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[g+1] <= t[MW] ? t[MW:1] : t[MW-1:0];
                    f_reg[g+1] <= {f_reg[g][FRAC_BITS-2:0], t[MW]};
                    e_reg[g+1] <= e_reg[g];
                end
            end
        end
    endgenerate

    assign l2   = {e_reg[FRAC_BITS], f_reg[FRAC_BITS]};
    assign prod = PW'(l2) * PW'(LN2_Q32) + (PW'(1) << 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg <= prod[32 +: LNW];
        end
    end

    assign ln = ln_reg;

endmodule

// ===== src/ntc_divider_temperature.sv =====
// ----------------------------------------------------------------------------
// NTC divider temperature
// Thermistor resistance, beta-equation temperature, current and power.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     contents
//  sample    in    valid/ready   divider_mv
//  result    out   valid/ready   temperature, resistance, current, power, status
//  cfg       in    cfg_we        cfg_index, cfg_data
//
// One word enters per cycle except in a stall; the pipeline depth is set by the
// log squaring stages plus the 17-stage temperature divider, or the 34-stage
// resistance divider. All stages advance together whenever the output
// register is empty or taken, so a stall holds every word in place. Reset
// clears the valid bits and loads the default configuration.
module ntc_divider_temperature import ntcdt_pkg::*; #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ntcdt_in_if.sink         sample,
    ntcdt_out_if.source      result
);

    localparam int F        = LOG_FRAC_BITS;
    localparam int LOGL     = F + 3;
    localparam int LNW      = F + 5;
    localparam int DNW      = F + 24;
    localparam int DKW      = F + 23;
    localparam int NKW      = F + 37;
    localparam int CW       = F + 40;
    localparam int RES_QW   = 34;
    localparam int CUR_QW   = 24;
    localparam int PWR_QW   = 27;
    localparam int TEMP_END = LOGL + 3 + KQW;
    localparam int RES_END  = 1 + RES_QW;
    localparam int CUR_END  = 1 + CUR_QW;
    localparam int PWR_END  = 1 + PWR_QW;
    localparam int LAST     = (TEMP_END > RES_END) ? TEMP_END : RES_END;

    logic [MV_W-1:0]   ref_reg;
    logic [RES_W-1:0]  rf_reg;
    logic [RES_W-1:0]  r25_reg;
    logic [BETA_W-1:0] beta_reg;

    logic              adv;
    logic [LAST:0]     vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= 13'd3294;
            rf_reg   <= 20'd10000;
            r25_reg  <= 20'd10000;
            beta_reg <= 14'd3950;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REFERENCE: ref_reg  <= cfg_data[MV_W-1:0];
                CFG_FIXED_RES: rf_reg   <= cfg_data[RES_W-1:0];
                CFG_NOMINAL:   r25_reg  <= cfg_data[RES_W-1:0];
                CFG_BETA:      beta_reg <= cfg_data[BETA_W-1:0];
            endcase
        end
    end

    assign adv          = !result.valid || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], sample.valid};
        end
    end

    // Front stage: range checks and the divider products.
    status_t         st_next;
    logic [MV_W-1:0] u;
    logic [MV_W-1:0] diff_next;

    status_t         st_a_reg;
    logic [MV_W-1:0] diff_a_reg;
    logic [XW-1:0]   num_a_reg;
    logic [XW-1:0]   m2_a_reg;
    logic [23:0]     kdiff_a_reg;
    logic [25:0]     udiff_a_reg;

    assign u         = sample.divider_mv;
    assign diff_next = ref_reg - u;

    always_comb
    begin
        priority if (ref_reg == '0)
            st_next = ST_BAD_REF;
        else if (rf_reg == '0)
            st_next = ST_BAD_RES;
        else if (u == '0 || u >= ref_reg)
            st_next = ST_RANGE;
        else if (beta_reg == '0)
            st_next = ST_BAD_BETA;
        else if (r25_reg == '0)
            st_next = ST_BAD_NOM;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_a_reg    <= st_next;
            diff_a_reg  <= diff_next;
            num_a_reg   <= XW'(rf_reg) * XW'(u);
            m2_a_reg    <= XW'(r25_reg) * XW'(diff_next);
            kdiff_a_reg <= 24'(diff_next) * 24'(MILLI);
            udiff_a_reg <= 26'(u) * 26'(diff_next);
        end
    end

    // Log lanes for R*U and R25*(Uref-U).
    logic [LNW-1:0] ln_x;
    logic [LNW-1:0] ln_y;

    ntcdt_log #(.FRAC_BITS(F), .LNW(LNW)) u_log_x (
        .clk (clk), .en (adv), .x (num_a_reg), .ln (ln_x)
    );

    ntcdt_log #(.FRAC_BITS(F), .LNW(LNW)) u_log_y (
        .clk (clk), .en (adv), .x (m2_a_reg), .ln (ln_y)
    );

    // Denominator of the Kelvin quotient, 100*beta + 29815*ln, scaled by 2^F.
    logic signed [DNW-1:0] d_ext;
    logic signed [DNW-1:0] den_next;
    logic signed [DNW-1:0] den_reg;
    logic [35:0]           tnb_reg;

    always_comb
    begin
        d_ext    = $signed({{(DNW-LNW){1'b0}}, ln_x}) - $signed({{(DNW-LNW){1'b0}}, ln_y});
        den_next = d_ext * $signed(DNW'(T25_CENTI))
                 + $signed((DNW'(beta_reg) * DNW'(HUNDRED)) << F);
    end

    always_ff @(posedge clk)
    begin
        tnb_reg <= 36'(beta_reg) * 36'(TN_SCALE);
        if (adv)
        begin
            den_reg <= den_next;
        end
    end

    // Final status and the rounded dividend for the Kelvin quotient.
    logic [2:0]     st_b;
    logic           low_res;
    logic [DKW-1:0] dpos;
    logic [NKW-1:0] nk_next;
    logic           hi_next;
    status_t        stf_next;

    logic [NKW-1:0] nk_reg;
    logic [DKW-1:0] dk_reg;
    logic           hi_reg;
    status_t        stf_reg;

    ntcdt_delay #(.W(3), .DEPTH(1 + LOGL)) u_dly_st (
        .clk (clk), .en (adv), .d (st_a_reg), .q (st_b)
    );

    always_comb
    begin
        low_res = den_reg[DNW-1] || (den_reg == '0);
        dpos    = den_reg[DKW-1:0];
        nk_next = (NKW'(tnb_reg) << F) + NKW'(dpos >> 1);
        hi_next = (CW'(nk_next) >= (CW'(dpos) << KQW));
        if (status_t'(st_b) != ST_OK)
            stf_next = status_t'(st_b);
        else if (low_res)
            stf_next = ST_LOW_RES;
        else
            stf_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nk_reg  <= nk_next;
            dk_reg  <= dpos;
            hi_reg  <= hi_next;
            stf_reg <= stf_next;
        end
    end

    // Dividers and their alignment to the output stage.
    logic [KQW-1:0]    k_q;
    logic [KQW-1:0]    k_al;
    logic [3:0]        sh_al;
    logic [RES_QW-1:0] r_q;
    logic [RES_QW-1:0] r_al;
    logic [CUR_QW-1:0] c_q;
    logic [CUR_QW-1:0] c_al;
    logic [PWR_QW-1:0] p_q;
    logic [PWR_QW-1:0] p_al;

    ntcdt_div #(.NW(NKW), .DW(DKW), .QW(KQW)) u_div_k (
        .clk (clk), .en (adv), .n (nk_reg), .d (dk_reg), .q (k_q)
    );

    ntcdt_div #(.NW(RES_QW), .DW(MV_W), .QW(RES_QW)) u_div_r (
        .clk (clk), .en (adv),
        .n   (RES_QW'(num_a_reg) + RES_QW'(diff_a_reg >> 1)),
        .d   (diff_a_reg), .q (r_q)
    );

    ntcdt_div #(.NW(CUR_QW), .DW(RES_W), .QW(CUR_QW)) u_div_c (
        .clk (clk), .en (adv),
        .n   (kdiff_a_reg + CUR_QW'(rf_reg >> 1)),
        .d   (rf_reg), .q (c_q)
    );

    ntcdt_div #(.NW(PWR_QW), .DW(RES_W), .QW(PWR_QW)) u_div_p (
        .clk (clk), .en (adv),
        .n   (PWR_QW'(udiff_a_reg) + PWR_QW'(rf_reg >> 1)),
        .d   (rf_reg), .q (p_q)
    );

    ntcdt_delay #(.W(KQW), .DEPTH(LAST - TEMP_END)) u_dly_k (
        .clk (clk), .en (adv), .d (k_q), .q (k_al)
    );

    ntcdt_delay #(.W(4), .DEPTH(KQW + LAST - TEMP_END)) u_dly_sh (
        .clk (clk), .en (adv), .d ({stf_reg, hi_reg}), .q (sh_al)
    );

    ntcdt_delay #(.W(RES_QW), .DEPTH(LAST - RES_END)) u_dly_r (
        .clk (clk), .en (adv), .d (r_q), .q (r_al)
    );

    ntcdt_delay #(.W(CUR_QW), .DEPTH(LAST - CUR_END)) u_dly_c (
        .clk (clk), .en (adv), .d (c_q), .q (c_al)
    );

    ntcdt_delay #(.W(PWR_QW), .DEPTH(LAST - PWR_END)) u_dly_p (
        .clk (clk), .en (adv), .d (p_q), .q (p_al)
    );

    // Output register with saturation; an error status zeroes the numbers.
    status_t     st_out;
    logic [15:0] temp_next;
    logic [31:0] res_next;
    logic [23:0] cur_next;
    logic [23:0] pwr_next;

    logic [15:0] temp_reg;
    logic [31:0] res_reg;
    logic [23:0] cur_reg;
    logic [23:0] pwr_reg;
    logic [2:0]  st_reg;

    always_comb
    begin
        st_out = status_t'(sh_al[3:1]);
        if (sh_al[0] || k_al > K_TOP)
            temp_next = TEMP_MAX;
        else
            temp_next = 16'(18'(k_al) - 18'(K_OFFSET));
        res_next = (r_al[RES_QW-1:32] != '0) ? 32'hFFFF_FFFF : r_al[31:0];
        cur_next = c_al;
        pwr_next = (p_al[PWR_QW-1:24] != '0) ? 24'hFF_FFFF : p_al[23:0];
        if (st_out != ST_OK)
        begin
            temp_next = '0;
            res_next  = '0;
            cur_next  = '0;
            pwr_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_reg <= temp_next;
            res_reg  <= res_next;
            cur_reg  <= cur_next;
            pwr_reg  <= pwr_next;
            st_reg   <= st_out;
        end
    end

    assign result.valid               = vld_reg[LAST];
    assign result.temperature_centi_c = temp_reg;
    assign result.resistance_ohm      = res_reg;
    assign result.current_ua          = cur_reg;
    assign result.power_uw            = pwr_reg;
    assign result.status              = st_reg;

    // An error word carries no numeric results.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_OK |->
            result.temperature_centi_c == '0 && result.resistance_ohm == '0 &&
            result.current_ua == '0 && result.power_uw == '0)
        else $error("error word with nonzero results");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.status <= ST_LOW_RES)
        else $error("undefined status code");

    a_temp_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_OK |->
            $signed(result.temperature_centi_c) >= -16'sd27315)
        else $error("temperature below absolute zero");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
